// ===== src/mbss_pkg.sv =====
// Shared types and constants for the masked byte signature scanner.
// Used by every module in src; depends on nothing else.
package mbss_pkg;

	// The pattern registers always hold sixteen bytes, whatever the window depth.
	localparam int PATTERN_SLOTS = 16;
	localparam int ADDR_W        = 48;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PAT_LOW  = 3'd0;
	localparam logic [2:0] REG_PAT_HIGH = 3'd1;
	localparam logic [2:0] REG_CARE     = 3'd2;
	localparam logic [2:0] REG_LENGTH   = 3'd3;
	localparam logic [2:0] REG_BASE     = 3'd4;

	// Result queue geometry.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_CW    = 3;

	typedef logic [7:0] byte_t;

	// Pattern set-up as seen by every cell of the window.
	typedef struct packed {
		logic [PATTERN_SLOTS-1:0][7:0] bytes;
		logic [PATTERN_SLOTS-1:0]      care;
		logic [4:0]                    len;
	} pat_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} res_t;

endpackage

// ===== src/mbss_cell.sv =====
// One position of the sliding window: holds a byte and checks it against its pattern byte.
// Depends on mbss_pkg.
module mbss_cell
	import mbss_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  shift,
	input  byte_t byte_in,
	input  pat_t  pat,
	output byte_t byte_out,
	output logic  ok
);

	byte_t      byte_q;
	logic [4:0] j;
	logic       in_use;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	// The byte held here is k bytes old, so it lines up with pattern byte len-1-k.
	always_comb begin
		j      = 5'(pat.len - 5'(IDX) - 5'd1);
		in_use = 5'(IDX) < pat.len;
		ok     = !in_use || !pat.care[j[3:0]] || (byte_q == pat.bytes[j[3:0]]);
	end

	assign byte_out = byte_q;

endmodule

// ===== src/mbss_fifo.sv =====
// Small result queue that decouples the scan pipeline from the result stream.
// Depends on mbss_pkg.
module mbss_fifo
	import mbss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  res_t             push_data,
	input  logic             pop,
	output logic             not_empty,
	output res_t             head,
	output logic [OQ_CW-1:0] count
);

	res_t             mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q;
	logic [OQ_AW-1:0] rd_q;
	logic [OQ_CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

	assign not_empty = cnt_q != '0;
	assign head      = mem[rd_q];
	assign count     = cnt_q;

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < OQ_CW'(OQ_DEPTH))
		else $error("result queue overflow");

	a_no_underflow : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("result queue underflow");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("result queue count did not follow a push");

endmodule

// ===== src/masked_byte_signature_scanner.sv =====
// Top level of the masked byte signature scanner: configuration registers, window, pipeline.
// Depends on mbss_pkg, mbss_cell and mbss_fifo.
//
// The scanner takes one byte of a memory region per request on the slave stream and looks for a
// pattern of up to sixteen bytes, any of which may be a wildcard (care bit clear). It accepts a
// byte in every clock cycle while the flow control below keeps s_tready high. A region gives
// exactly one result: found with base_address plus the offset of the first match, or not found
// with a zero address once its last byte (tlast) has been seen. Bytes after a match are consumed
// without further results. On its way to the master stream a byte shifts into the window of
// PATTERN_MAX cells, stage 2 registers the per-cell compares combined with the length check, and
// the result logic adds the offset to the base address, applies the one-result-per-region rule
// and writes the result queue. Results wait in a four-entry queue; a byte is taken only while
// the queued results plus the bytes in the two pipeline stages number fewer than four, so when
// every byte closes a region any stall on the master side already holds the input back, while
// results only at region ends rarely stop it. A zero pattern length, or one beyond PATTERN_MAX,
// never matches. Configuration is written through the cfg port, which always accepts, and must
// only change while no region is in progress.
module masked_byte_signature_scanner
	import mbss_pkg::*;
#(
	parameter int PATTERN_MAX = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave stream: tdata[7:0] = data_byte; tlast = last_byte
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	// master stream: tdata[47:0] = match_address; tuser[0] = found
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ADDR_W-1:0] m_tdata,
	output logic              m_tuser,
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	// Configuration registers.
	logic [63:0]       pat_low_q;
	logic [63:0]       pat_high_q;
	logic [15:0]       care_q;
	logic [4:0]        len_q;
	logic [ADDR_W-1:0] base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= '0;
			base_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_CARE:     care_q     <= cfg_data[15:0];
				REG_LENGTH:   len_q      <= cfg_data[4:0];
				REG_BASE:     base_q     <= cfg_data[ADDR_W-1:0];
				default:      ;
			endcase
		end
	end

	pat_t pat;
	assign pat.bytes = {pat_high_q, pat_low_q};
	assign pat.care  = care_q;
	assign pat.len   = len_q;

	// Handshake and flow control. A byte is only taken when the queue has room for every result
	// that the bytes already in the pipeline could still produce.
	logic             accept;
	logic             v_s1;
	logic             v_s2;
	logic [OQ_CW-1:0] oq_cnt;
	logic [OQ_CW:0]   committed;

	assign committed = {1'b0, oq_cnt} + (OQ_CW + 1)'(v_s1) + (OQ_CW + 1)'(v_s2);
	assign s_tready  = committed < (OQ_CW + 1)'(OQ_DEPTH);
	assign accept    = s_tvalid && s_tready;

	// Byte counter for the region, saturating, cleared after the last byte.
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= s_tlast ? '0 : cnt_inc;
		end
	end

	// The window: a chain of cells, newest byte in cell 0. Cells only hold bytes of the current
	// region wherever they are compared, since a compare needs the count to reach the length.
	byte_t                  chain [PATTERN_MAX+1];
	logic [PATTERN_MAX-1:0] cell_ok;

	assign chain[0] = s_tdata;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		mbss_cell #(
			.IDX(k)
		) u_cell (
			.clk     (clk),
			.shift   (accept),
			.byte_in (chain[k]),
			.pat     (pat),
			.byte_out(chain[k+1]),
			.ok      (cell_ok[k])
		);
	end

	// Stage 1: the window now holds the accepted byte.
	logic                  last_s1;
	logic [COUNT_BITS-1:0] cnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= s_tlast;
			cnt_s1  <= cnt_inc;
		end
	end

	logic len_ok;
	logic cand;

	assign len_ok = (len_q != '0) && (len_q <= 5'(PATTERN_MAX));
	assign cand   = len_ok && (cnt_s1 >= COUNT_BITS'(len_q)) && (&cell_ok);

	// Stage 2: candidate match and offset of its first byte.
	logic                  last_s2;
	logic                  cand_s2;
	logic [COUNT_BITS-1:0] off_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2 <= last_s1;
			cand_s2 <= cand;
			off_s2  <= cnt_s1 - COUNT_BITS'(len_q);
		end
	end

	// One result per region: the first match, or a miss at the last byte.
	logic rep_q;
	logic hit;
	logic push;
	res_t push_data;

	assign hit  = v_s2 && cand_s2 && !rep_q;
	assign push = hit || (v_s2 && last_s2 && !rep_q);

	always_comb begin
		push_data.found = hit;
		push_data.addr  = hit ? base_q + ADDR_W'(off_s2) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= 1'b0;
		end else if (v_s2) begin
			rep_q <= last_s2 ? 1'b0 : (rep_q || cand_s2);
		end
	end

	res_t oq_head;

	mbss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (m_tvalid && m_tready),
		.not_empty(m_tvalid),
		.head     (oq_head),
		.count    (oq_cnt)
	);

	assign m_tdata = oq_head.addr;
	assign m_tuser = oq_head.found;

	// The queue plus the bytes in flight never exceed its depth.
	a_credit : assert property (@(posedge clk) disable iff (!arst_n)
		committed <= (OQ_CW + 1)'(OQ_DEPTH))
		else $error("results in flight exceed queue depth");

	// The end of a region always leaves the match flag clear for the next one.
	a_region_clear : assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && last_s2 |=> !rep_q)
		else $error("match flag survived the end of a region");

	// No further result, found or miss, once a match has been reported in the region.
	a_single_match : assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> !push)
		else $error("second result in one region");

	// A miss result carries a zero address and comes only at the last byte of a region.
	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_data.found |-> push_data.addr == '0 && last_s2)
		else $error("miss result with address or before region end");

endmodule
